>>> hw/rtl/stack_machine_operand_unit_top_assert.svh
// Assertion macros used by the checker of the operand stack unit.
`ifndef STACK_MACHINE_OPERAND_UNIT_TOP_ASSERT_SVH
`define STACK_MACHINE_OPERAND_UNIT_TOP_ASSERT_SVH

// Clocked check, quiet while reset is asserted.
`define SMOU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SMOU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/smou_pkg.sv
`default_nettype none

package smou_pkg;

	localparam int WORD_W   = 32;
	localparam int DEPTH_W  = 11;
	localparam int BYTE_W   = 8;
	localparam int REQ_W    = 4;
	localparam int STATUS_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_BIPUSH = 4'd0;
	localparam logic [REQ_W-1:0] REQ_IN     = 4'd1;
	localparam logic [REQ_W-1:0] REQ_OUT    = 4'd2;
	localparam logic [REQ_W-1:0] REQ_ADD    = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SUB    = 4'd4;
	localparam logic [REQ_W-1:0] REQ_AND    = 4'd5;
	localparam logic [REQ_W-1:0] REQ_OR     = 4'd6;
	localparam logic [REQ_W-1:0] REQ_SWAP   = 4'd7;
	localparam logic [REQ_W-1:0] REQ_POP    = 4'd8;
	localparam logic [REQ_W-1:0] REQ_DUP    = 4'd9;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd3;

	// where the second-from-top word comes from after an operation
	typedef enum logic [1:0] {
		SEC_KEEP,
		SEC_FROM_TOP,
		SEC_FROM_MEM
	} sec_sel_t;

endpackage

`default_nettype wire

>>> hw/rtl/stack_machine_operand_unit_top.sv
// A request waits in the input register; its response is held in the result register.
// Throughput: one request per cycle, pops and binary ops too, while no response stalls.
// The top two words sit in registers and the single-port memory refills the second
// word through its registered read data, which is forwarded to the next request.
// Reset (arst_n low, asynchronous) empties the stack; the memory is not cleared.
`default_nettype none

module stack_machine_operand_unit_top #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// request channel
	input  wire logic                                  req_valid,
	output logic                                       req_stall,
	input  wire logic [smou_pkg::REQ_W-1:0]            req_type,
	input  wire logic signed [smou_pkg::WORD_W-1:0]    value,
	input  wire logic                                  byte_available,
	// response channel
	output logic                                       rsp_valid,
	input  wire logic                                  rsp_stall,
	output logic signed [smou_pkg::WORD_W-1:0]         top_word,
	output logic [smou_pkg::DEPTH_W-1:0]               depth,
	output logic [smou_pkg::BYTE_W-1:0]                out_byte,
	output logic                                       out_valid,
	output logic [smou_pkg::STATUS_W-1:0]              status
);

	// Stack pointer must hold STACK_DEPTH itself; memory index covers the entries only.
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int W   = smou_pkg::WORD_W;

	// ------------------------------------------------------------------
	// Input register: hold one request until it is executed.
	// ------------------------------------------------------------------
	logic                          valid_s1;
	logic [smou_pkg::REQ_W-1:0]    req_type_s1;
	logic [W-1:0]                  value_s1;
	logic                          avail_s1;

	// ------------------------------------------------------------------
	// Stack state. Entry i of the stack lives at memory index i, but the
	// top word (index sp-1) and the second word (index sp-2) are cached.
	// The memory only holds up to date contents below index sp-2.
	// ------------------------------------------------------------------
	logic [SPW-1:0]                sp_q;
	logic [W-1:0]                  top_q;
	logic [W-1:0]                  sec_q;
	logic                          sec_mem_q;   // second word is in rd_data_q
	logic [W-1:0]                  rd_data_q;
	logic [W-1:0]                  mem [STACK_DEPTH];

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	logic                          rsp_valid_q;
	logic [W-1:0]                  top_word_q;
	logic [smou_pkg::DEPTH_W-1:0]  depth_q;
	logic [smou_pkg::BYTE_W-1:0]   out_byte_q;
	logic                          out_valid_q;
	logic [smou_pkg::STATUS_W-1:0] status_q;

	// Execute the held request whenever the result register is free or being drained.
	logic exec;
	assign exec      = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !exec;

	// Forward the refilled second word straight from the memory read register.
	logic [W-1:0] sec_eff;
	assign sec_eff = sec_mem_q ? rd_data_q : sec_q;

	// ------------------------------------------------------------------
	// Decode and execute.
	// ------------------------------------------------------------------
	logic                          known;
	logic                          grows;
	logic [1:0]                    need;
	logic                          underflow;
	logic                          overflow;
	logic                          do_op;
	logic [W-1:0]                  op_top;
	logic [SPW-1:0]                op_sp;
	smou_pkg::sec_sel_t            op_sec;
	logic [W-1:0]                  nxt_top;
	logic [SPW-1:0]                nxt_sp;
	logic [smou_pkg::STATUS_W-1:0] nxt_status;
	logic                          nxt_out_valid;
	logic [smou_pkg::BYTE_W-1:0]   nxt_out_byte;
	logic                          mem_wr;
	logic                          mem_rd;
	logic [AW-1:0]                 mem_addr;
	logic [SPW-1:0]                sp_m2;
	logic [SPW-1:0]                sp_m3;

	assign sp_m2 = sp_q - SPW'(2);
	assign sp_m3 = sp_q - SPW'(3);

	always_comb begin
		known = 1'b1;
		grows = 1'b0;
		need  = 2'd0;
		unique case (req_type_s1) inside
			smou_pkg::REQ_BIPUSH, smou_pkg::REQ_IN: begin
				grows = 1'b1;
			end
			smou_pkg::REQ_OUT, smou_pkg::REQ_POP: begin
				need = 2'd1;
			end
			smou_pkg::REQ_DUP: begin
				need  = 2'd1;
				grows = 1'b1;
			end
			smou_pkg::REQ_ADD, smou_pkg::REQ_SUB, smou_pkg::REQ_AND,
			smou_pkg::REQ_OR, smou_pkg::REQ_SWAP: begin
				need = 2'd2;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign underflow = known && (sp_q < SPW'(need));
	assign overflow  = known && !underflow && grows && (sp_q >= SPW'(STACK_DEPTH));
	assign do_op     = known && !underflow && !overflow;

	always_comb begin
		op_top = top_q;
		op_sp  = sp_q;
		op_sec = smou_pkg::SEC_KEEP;
		case (req_type_s1)
			smou_pkg::REQ_BIPUSH: begin
				op_top = value_s1;
				op_sp  = sp_q + SPW'(1);
				op_sec = smou_pkg::SEC_FROM_TOP;
			end
			smou_pkg::REQ_IN: begin
				op_top = avail_s1 ? {{(W-8){1'b0}}, value_s1[7:0]} : '0;
				op_sp  = sp_q + SPW'(1);
				op_sec = smou_pkg::SEC_FROM_TOP;
			end
			smou_pkg::REQ_DUP: begin
				op_sp  = sp_q + SPW'(1);
				op_sec = smou_pkg::SEC_FROM_TOP;
			end
			smou_pkg::REQ_OUT, smou_pkg::REQ_POP: begin
				op_top = sec_eff;
				op_sp  = sp_q - SPW'(1);
				op_sec = smou_pkg::SEC_FROM_MEM;
			end
			smou_pkg::REQ_ADD: begin
				op_top = sec_eff + top_q;
				op_sp  = sp_q - SPW'(1);
				op_sec = smou_pkg::SEC_FROM_MEM;
			end
			smou_pkg::REQ_SUB: begin
				op_top = sec_eff - top_q;
				op_sp  = sp_q - SPW'(1);
				op_sec = smou_pkg::SEC_FROM_MEM;
			end
			smou_pkg::REQ_AND: begin
				op_top = sec_eff & top_q;
				op_sp  = sp_q - SPW'(1);
				op_sec = smou_pkg::SEC_FROM_MEM;
			end
			smou_pkg::REQ_OR: begin
				op_top = sec_eff | top_q;
				op_sp  = sp_q - SPW'(1);
				op_sec = smou_pkg::SEC_FROM_MEM;
			end
			smou_pkg::REQ_SWAP: begin
				op_top = sec_eff;
				op_sec = smou_pkg::SEC_FROM_TOP;
			end
			default: begin
				op_top = top_q;
			end
		endcase
	end

	always_comb begin
		nxt_top       = do_op ? op_top : top_q;
		nxt_sp        = do_op ? op_sp : sp_q;
		nxt_status    = underflow ? smou_pkg::ST_UNDER :
		                overflow  ? smou_pkg::ST_OVER  : smou_pkg::ST_OK;
		nxt_out_valid = do_op && (req_type_s1 == smou_pkg::REQ_OUT);
		nxt_out_byte  = nxt_out_valid ? top_q[7:0] : '0;
	end

	// A push spills the old second word; a pop or binary op refills the new second word.
	// Neither touches the memory when the affected entry lies below the stack.
	assign mem_wr   = exec && do_op && grows && (sp_q >= SPW'(2));
	assign mem_rd   = exec && do_op && (op_sec == smou_pkg::SEC_FROM_MEM) &&
	                  (sp_q >= SPW'(3));
	assign mem_addr = mem_wr ? AW'(sp_m2) : AW'(sp_m3);

	// ------------------------------------------------------------------
	// Single-port memory, registered read data.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[mem_addr] <= sec_eff;
		end else if (mem_rd) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			sp_q        <= '0;
			sec_mem_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// take a new transfer, or drop the held one once executed
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec) begin
				sp_q <= nxt_sp;
				if (do_op) begin
					unique case (op_sec)
						smou_pkg::SEC_FROM_TOP: sec_mem_q <= 1'b0;
						smou_pkg::SEC_FROM_MEM: sec_mem_q <= 1'b1;
						default:                sec_mem_q <= sec_mem_q;
					endcase
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_type_s1 <= req_type;
			value_s1    <= value;
			avail_s1    <= byte_available;
		end
		if (exec) begin
			top_q <= nxt_top;
			if (do_op && (op_sec == smou_pkg::SEC_FROM_TOP)) begin
				sec_q <= top_q;
			end
			top_word_q  <= (nxt_sp == '0) ? '0 : nxt_top;
			depth_q     <= smou_pkg::DEPTH_W'(nxt_sp);
			out_byte_q  <= nxt_out_byte;
			out_valid_q <= nxt_out_valid;
			status_q    <= nxt_status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign top_word  = top_word_q;
	assign depth     = depth_q;
	assign out_byte  = out_byte_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

`default_nettype wire

>>> hw/rtl/smou_checker.sv
`default_nettype none

`include "stack_machine_operand_unit_top_assert.svh"

module smou_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 req_valid,
	input wire logic                                 req_stall,
	input wire logic [smou_pkg::REQ_W-1:0]           req_type,
	input wire logic signed [smou_pkg::WORD_W-1:0]   value,
	input wire logic                                 byte_available,
	input wire logic                                 rsp_valid,
	input wire logic                                 rsp_stall,
	input wire logic signed [smou_pkg::WORD_W-1:0]   top_word,
	input wire logic [smou_pkg::DEPTH_W-1:0]         depth,
	input wire logic [smou_pkg::BYTE_W-1:0]          out_byte,
	input wire logic                                 out_valid,
	input wire logic [smou_pkg::STATUS_W-1:0]        status
);

	// a stalled response stays offered
	`SMOU_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")

	// a stalled response keeps its payload
	`SMOU_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(top_word) && $stable(depth) && $stable(out_byte) && $stable(out_valid) && $stable(status), "response payload changed while stalled")

	// an emitted byte only comes from a successful out
	`SMOU_ASSERT(a_out_ok, rsp_valid && out_valid |-> status == smou_pkg::ST_OK, "byte emitted with error status")

	// no byte field without the emit flag, and no reserved status code
	`SMOU_ASSERT(a_byte_idle, rsp_valid && !out_valid |-> out_byte == '0 && status != smou_pkg::ST_RESERVED, "stray byte or reserved status")

	// a stalled request stays offered with its payload unchanged
	`SMOU_ASSERT(a_req_stable, req_valid && req_stall |=> req_valid && $stable(req_type) && $stable(value) && $stable(byte_available), "request changed while stalled")

endmodule

bind stack_machine_operand_unit_top smou_checker u_smou_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;

	localparam int STACK_DEPTH = 1024;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 12;
	// Longest stretch without any transfer before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 300;
	// Depth above which random traffic leans towards shrinking the stack.
	localparam int SOFT_CEILING = 40;
	localparam int MISMATCH_SHOWN = 10;
	// Request codes the block does not decode.
	localparam logic [smou_pkg::REQ_W-1:0] REQ_NONE_FIRST = 4'd10;
	localparam logic [smou_pkg::REQ_W-1:0] REQ_NONE_LAST = 4'd15;

	// One response as the block should present it.
	typedef struct packed {
		logic [smou_pkg::WORD_W-1:0]   top;
		logic [smou_pkg::DEPTH_W-1:0]  words;
		logic [smou_pkg::BYTE_W-1:0]   byte_out;
		logic                          byte_ok;
		logic [smou_pkg::STATUS_W-1:0] code;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                               req_valid = 1'b0;
	logic                               req_stall;
	logic [smou_pkg::REQ_W-1:0]         req_type = smou_pkg::REQ_BIPUSH;
	logic signed [smou_pkg::WORD_W-1:0] value = '0;
	logic                               byte_available = 1'b0;

	logic                               rsp_valid;
	logic                               rsp_stall = 1'b0;
	logic signed [smou_pkg::WORD_W-1:0] top_word;
	logic [smou_pkg::DEPTH_W-1:0]       depth;
	logic [smou_pkg::BYTE_W-1:0]        out_byte;
	logic                               out_valid;
	logic [smou_pkg::STATUS_W-1:0]      status;

	// Shadow copy of the stack, advanced once per accepted request.
	logic [smou_pkg::WORD_W-1:0] shadow_mem [STACK_DEPTH];
	int                          shadow_count = 0;

	// Responses owed by the block, oldest first.
	stack_result_t results_due [$];

	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	always #(HALF_PERIOD) clk = ~clk;

	stack_machine_operand_unit_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.value         (value),
		.byte_available(byte_available),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.top_word      (top_word),
		.depth         (depth),
		.out_byte      (out_byte),
		.out_valid     (out_valid),
		.status        (status)
	);

	// Apply one request to the shadow stack and return the response it owes.
	// Refused requests (underflow, overflow) leave the shadow untouched;
	// unknown codes do nothing and report success.
	function automatic stack_result_t stack_apply(input logic [smou_pkg::REQ_W-1:0] op,
			input logic [smou_pkg::WORD_W-1:0] imm, input logic avail);
		stack_result_t               r;
		int                          need;
		logic                        grows;
		logic [smou_pkg::WORD_W-1:0] t;
		logic [smou_pkg::WORD_W-1:0] s;
		r = '0;
		need = 0;
		grows = 1'b0;
		case (op)
			smou_pkg::REQ_BIPUSH, smou_pkg::REQ_IN: grows = 1'b1;
			smou_pkg::REQ_OUT, smou_pkg::REQ_POP: need = 1;
			smou_pkg::REQ_DUP: begin
				need = 1;
				grows = 1'b1;
			end
			smou_pkg::REQ_ADD, smou_pkg::REQ_SUB, smou_pkg::REQ_AND, smou_pkg::REQ_OR,
			smou_pkg::REQ_SWAP: need = 2;
			default: ;
		endcase
		r.code = smou_pkg::ST_OK;
		if (op <= smou_pkg::REQ_DUP) begin
			if (shadow_count < need) begin
				r.code = smou_pkg::ST_UNDER;
			end else if (grows && shadow_count >= STACK_DEPTH) begin
				r.code = smou_pkg::ST_OVER;
			end else begin
				t = (shadow_count >= 1) ? shadow_mem[shadow_count - 1] : '0;
				s = (shadow_count >= 2) ? shadow_mem[shadow_count - 2] : '0;
				case (op)
					smou_pkg::REQ_BIPUSH: begin
						shadow_mem[shadow_count] = imm;
						shadow_count++;
					end
					smou_pkg::REQ_IN: begin
						shadow_mem[shadow_count] = avail ? {24'd0, imm[7:0]} : '0;
						shadow_count++;
					end
					smou_pkg::REQ_OUT: begin
						r.byte_out = t[7:0];
						r.byte_ok = 1'b1;
						shadow_count--;
					end
					smou_pkg::REQ_ADD: begin
						shadow_mem[shadow_count - 2] = s + t;
						shadow_count--;
					end
					smou_pkg::REQ_SUB: begin
						shadow_mem[shadow_count - 2] = s - t;
						shadow_count--;
					end
					smou_pkg::REQ_AND: begin
						shadow_mem[shadow_count - 2] = s & t;
						shadow_count--;
					end
					smou_pkg::REQ_OR: begin
						shadow_mem[shadow_count - 2] = s | t;
						shadow_count--;
					end
					smou_pkg::REQ_SWAP: begin
						shadow_mem[shadow_count - 2] = t;
						shadow_mem[shadow_count - 1] = s;
					end
					smou_pkg::REQ_POP: shadow_count--;
					smou_pkg::REQ_DUP: begin
						shadow_mem[shadow_count] = t;
						shadow_count++;
					end
					default: ;
				endcase
			end
		end
		r.top = (shadow_count > 0) ? shadow_mem[shadow_count - 1] : '0;
		r.words = smou_pkg::DEPTH_W'(shadow_count);
		return r;
	endfunction

	// Choose a request, steering the depth so that it wanders near empty
	// (underflow) as well as a few dozen words deep.
	function automatic logic [smou_pkg::REQ_W-1:0] pick_op();
		int r;
		if ($urandom_range(99) < 3)
			return smou_pkg::REQ_W'($urandom_range(REQ_NONE_LAST, REQ_NONE_FIRST));
		r = $urandom_range(99);
		if (shadow_count > SOFT_CEILING)
			r = $urandom_range(99, 48);
		if (r < 40)
			return $urandom_range(1) ? smou_pkg::REQ_BIPUSH : smou_pkg::REQ_IN;
		if (r < 48)
			return smou_pkg::REQ_DUP;
		if (r < 83) begin
			case ($urandom_range(4))
				0: return smou_pkg::REQ_ADD;
				1: return smou_pkg::REQ_SUB;
				2: return smou_pkg::REQ_AND;
				3: return smou_pkg::REQ_OR;
				default: return smou_pkg::REQ_SWAP;
			endcase
		end
		return $urandom_range(1) ? smou_pkg::REQ_OUT : smou_pkg::REQ_POP;
	endfunction

	// Favour the corner words now and then, otherwise any 32-bit pattern.
	function automatic logic [smou_pkg::WORD_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Offer one request and hold it until it is transferred. Entered and left
	// just after a falling edge, so valid stays high between back-to-back
	// requests and only ever drops for a sender gap.
	task automatic send_op(input logic [smou_pkg::REQ_W-1:0] op,
			input logic [smou_pkg::WORD_W-1:0] imm = '0, input logic avail = 1'b0);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= op;
		value <= imm;
		byte_available <= avail;
		do
			@(posedge clk);
		while (req_stall);
		results_due.push_back(stack_apply(op, imm, avail));
		@(negedge clk);
	endtask

	// Hand-picked sequence: every operation, refusals on an empty and a
	// one-word stack, arithmetic on the corner words, the input byte with and
	// without availability, and the undecoded request codes.
	task automatic test_directed_ops();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_op(smou_pkg::REQ_OUT);
		send_op(smou_pkg::REQ_POP);
		send_op(smou_pkg::REQ_DUP);
		send_op(smou_pkg::REQ_ADD);
		send_op(smou_pkg::REQ_SUB);
		send_op(smou_pkg::REQ_AND);
		send_op(smou_pkg::REQ_OR);
		send_op(smou_pkg::REQ_SWAP);
		send_op(smou_pkg::REQ_BIPUSH, 32'h7FFF_FFFF);
		send_op(smou_pkg::REQ_SWAP);
		send_op(smou_pkg::REQ_BIPUSH, 32'h8000_0000);
		send_op(smou_pkg::REQ_ADD);
		send_op(smou_pkg::REQ_BIPUSH, 32'hFFFF_FFFF);
		send_op(smou_pkg::REQ_SUB);
		send_op(smou_pkg::REQ_IN, 32'hFFFF_FFAB, 1'b1);
		send_op(smou_pkg::REQ_IN, 32'h0000_0055, 1'b0);
		send_op(smou_pkg::REQ_SWAP);
		send_op(smou_pkg::REQ_OR);
		send_op(smou_pkg::REQ_DUP);
		send_op(smou_pkg::REQ_AND);
		send_op(smou_pkg::REQ_OUT, 32'hFFFF_FFFF, 1'b1);
		send_op(smou_pkg::REQ_POP);
		send_op(REQ_NONE_FIRST, 32'hFFFF_FFFF, 1'b1);
		send_op(REQ_NONE_LAST);
	endtask

	// Hold the receiver off for a long stretch while requests keep coming,
	// so the block backs up and stalls its request side.
	task automatic test_stall_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (40)
			send_op(pick_op(), pick_value(), 1'($urandom_range(1)));
	endtask

	// Random traffic under the given idling; undecoded requests do not count.
	task automatic test_random_traffic(input int count, input int sender_idle,
			input int receiver_idle);
		int                         sent;
		logic [smou_pkg::REQ_W-1:0] op;
		send_idle_pct = sender_idle;
		recv_stall_pct = receiver_idle;
		sent = 0;
		while (sent < count) begin
			op = pick_op();
			send_op(op, pick_value(), 1'($urandom_range(1)));
			if (op <= smou_pkg::REQ_DUP)
				sent++;
		end
	endtask

	// Receiver: drive stall at the falling edge, either from a pending
	// hold-off or at random.
	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Compare every response transfer against the oldest owed result.
	always @(posedge clk) begin : rsp_check
		stack_result_t got;
		stack_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.top = top_word;
			got.words = depth;
			got.byte_out = out_byte;
			got.byte_ok = out_valid;
			got.code = status;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOWN)
					$display("%0t: response with nothing owed: top %h depth %0d byte %h/%b st %0d",
						$realtime, got.top, got.words, got.byte_out, got.byte_ok, got.code);
			end else begin
				want = results_due.pop_front();
				if (got.top !== want.top || got.words !== want.words ||
						got.byte_out !== want.byte_out || got.byte_ok !== want.byte_ok ||
						got.code !== want.code) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOWN)
						$display("%0t: top %h/%h depth %0d/%0d byte %h/%h valid %b/%b st %0d/%0d (exp/got)",
							$realtime, want.top, got.top, want.words, got.words,
							want.byte_out, got.byte_out, want.byte_ok, got.byte_ok,
							want.code, got.code);
				end
			end
		end
	end

	// Watchdog: give up once nothing has been transferred for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Sequence: reset once, run each test in turn, drain, then report.
	initial begin : main
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_ops();
		test_random_traffic(260, 21, 81);
		test_random_traffic(260, 81, 21);
		test_stall_pressure();
		test_random_traffic(260, 0, 0);
		req_valid <= 1'b0;
		// drain what is still owed, then watch for strays
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/smou_pkg.sv
hw/rtl/stack_machine_operand_unit_top.sv
hw/rtl/smou_checker.sv
bench/tb_top.sv
